### hw/rtl/dtas_pkg.sv
// Package for the DMA transfer address sequencer.
// Holds sizes, payload structs, codes and controller/datapath interface types.
// No dependencies.
package dtas_pkg;

   // Sizes
   localparam int NUM_CORES      = 4;
   localparam int IO_ADDR_BITS   = 8;
   localparam int CORE_ADDR_BITS = 12;
   localparam int MAX_LENGTH     = 8;
   localparam int MAX_STRIDE     = 8;
   localparam int MAX_CHANNELS   = 8;

   localparam int PAGE_SIZE = 1 << IO_ADDR_BITS;
   localparam int MAP_DEPTH = NUM_CORES * PAGE_SIZE;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam int MAP_W     = CORE_ADDR_BITS + 1;

   // Field widths fixed by the interface
   localparam int CORE_ID_W  = 2;
   localparam int LEN_W      = 4;
   localparam int MODE_W     = 3;
   localparam int CHAN_W     = 3;
   localparam int CHAN_CNT_W = 4;
   localparam int ERR_W      = 3;
   localparam int CSR_IDX_W  = 2;

   // Run counters hold values up to the larger of the two maxima
   localparam int CNT_MAX = (MAX_LENGTH > MAX_STRIDE) ? MAX_LENGTH : MAX_STRIDE;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);
   // Width of an io address plus an offset, wide enough to compare to the page size
   localparam int SUM_W   = IO_ADDR_BITS + CNT_W + 1;

   // Request kinds
   typedef enum logic {
      REQ_MAP_WRITE = 1'b0,
      REQ_TRANSFER  = 1'b1
   } req_kind_type;

   // Transfer modes
   typedef enum logic [MODE_W-1:0] {
      MODE_SCALAR  = 3'd0,
      MODE_SCATTER = 3'd1,
      MODE_GATHER  = 3'd2,
      MODE_VECTOR  = 3'd3,
      MODE_VEC2D   = 3'd4
   } mode_type;

   // Result error codes
   typedef enum logic [ERR_W-1:0] {
      ERR_NONE         = 3'd0,
      ERR_SRC_UNMAPPED = 3'd1,
      ERR_DST_UNMAPPED = 3'd2,
      ERR_DST_CHANNEL  = 3'd3,
      ERR_SRC_CHANNEL  = 3'd4
   } err_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHAN_CORE0 = 2'd0,
      CSR_CHAN_CORE1 = 2'd1,
      CSR_CHAN_CORE2 = 2'd2,
      CSR_CHAN_CORE3 = 2'd3
   } csr_index_type;

   // Request payload
   typedef struct packed {
      logic                      req_type;
      logic [CORE_ID_W-1:0]      source_core;
      logic [CORE_ID_W-1:0]      dest_core;
      logic [IO_ADDR_BITS-1:0]   src_base;
      logic [IO_ADDR_BITS-1:0]   dst_base;
      logic [CORE_ADDR_BITS-1:0] map_core_addr;
      logic                      map_valid;
      logic [MODE_W-1:0]         transfer_mode;
      logic [LEN_W-1:0]          length;
      logic [LEN_W-1:0]          stride;
      logic                      source_live;
   } dtas_req_type;

   // Result payload
   typedef struct packed {
      logic [CORE_ADDR_BITS-1:0] src_core_addr;
      logic [CORE_ADDR_BITS-1:0] dst_core_addr;
      logic [CHAN_W-1:0]         source_chan;
      logic [CHAN_W-1:0]         dest_chan;
      logic                      read_from_repeater;
      logic [ERR_W-1:0]          error_code;
      logic                      last;
   } dtas_rsp_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_READ  = 2'd2,
      ST_CHECK = 2'd3
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic read;
      logic emit;
   } dtas_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
      logic empty;
      logic stop;
   } dtas_status_type;

endpackage

### hw/rtl/dma_transfer_address_sequencer.sv
// Top level of the DMA transfer address sequencer.
// Joins the controller (dtas_ctrl) and the datapath (dtas_datapath); uses dtas_pkg.
//
// After reset the block clears all 1024 entries of its io-to-core address
// table, one entry per cycle; busy stays high meanwhile, and channel count
// writes on the csr port are taken at any time (csr_ready is always high). A
// request transaction is taken when start is high and busy is low. A map write
// goes into the table as it is taken. A transfer loads its fields and then,
// for each element, first reads the table at both the source and destination
// address and then checks and registers the result; a run has up to 64
// elements. Results come out on rsp_valid / rsp_data for exactly one cycle
// each and cannot be held off; the last one of a run has last set, and a
// failed check ends the run with an error result. Runs that produce no
// element (zero length, zero rows, unknown mode) give no result.
module dma_transfer_address_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  dtas_pkg::dtas_req_type           req_data,
   output logic                             rsp_valid,
   output dtas_pkg::dtas_rsp_type           rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dtas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dtas_pkg::CHAN_CNT_W-1:0]  csr_data
);
   import dtas_pkg::*;

   dtas_cmd_type    cmd;
   dtas_status_type status;

   assign csr_ready = 1'b1;

   // Sequence the transaction
   dtas_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .is_transfer (req_data.req_type == REQ_TRANSFER),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   // Translate and check each element
   dtas_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### hw/rtl/dtas_ctrl.sv
// Controller state machine of the DMA transfer address sequencer.
// Sequences table clearing, request load, table read and result check.
// Depends on dtas_pkg.
module dtas_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     is_transfer,
   input  dtas_pkg::dtas_status_type status,
   output dtas_pkg::dtas_cmd_type    cmd,
   output logic                     busy
);
   import dtas_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (is_transfer) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // drop runs that produce nothing
            if (status.empty) begin
               state_in = ST_IDLE;
            end else begin
               cmd.read = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.emit = 1'b1;
            if (status.stop) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

### hw/rtl/dtas_datapath.sv
// Datapath of the DMA transfer address sequencer: address table, run counters,
// channel count registers, translation, checks and the result register.
// Depends on dtas_pkg.
module dtas_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  dtas_pkg::dtas_cmd_type           cmd,
   output dtas_pkg::dtas_status_type        status,
   input  dtas_pkg::dtas_req_type           req_data,
   input  logic                             csr_valid,
   input  logic [dtas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dtas_pkg::CHAN_CNT_W-1:0]  csr_data,
   output logic                             rsp_valid,
   output dtas_pkg::dtas_rsp_type           rsp_data
);
   import dtas_pkg::*;

   // Address table: valid bit over core address
   logic [MAP_W-1:0] map_mem [MAP_DEPTH];

   logic [MAP_AW-1:0]     clr_idx_ff;
   logic [MAP_AW-1:0]     clr_idx_in;
   logic [CHAN_CNT_W-1:0] chan0_ff, chan1_ff, chan2_ff, chan3_ff;

   // Latched transfer
   logic [CORE_ID_W-1:0]    source_core_ff;
   logic [CORE_ID_W-1:0]    dest_core_ff;
   logic [IO_ADDR_BITS-1:0] src_base_ff;
   logic [IO_ADDR_BITS-1:0] dst_base_ff;
   logic [MODE_W-1:0]       mode_ff;
   logic [CNT_W-1:0]        len_ff;
   logic [CNT_W-1:0]        rows_ff;
   logic                    en_ff;
   logic [CHAN_CNT_W-1:0]   src_chans_ff;
   logic [CHAN_CNT_W-1:0]   dst_chans_ff;

   // Run counters
   logic [CNT_W-1:0] elem_ff, elem_in;
   logic [CNT_W-1:0] row_ff, row_in;

   // Read stage
   logic [MAP_W-1:0] src_rd_ff, dst_rd_ff;
   logic             src_in_range_ff, dst_in_range_ff;
   logic [CNT_W-1:0] sch_ff, dch_ff;
   logic             final_ff;

   logic                  rsp_valid_ff;
   dtas_rsp_type          rsp_data_ff;

   logic [CNT_W-1:0]      src_off, dst_off, sch, dch;
   logic [SUM_W-1:0]      src_sum, dst_sum;
   logic                  src_in_range, dst_in_range;
   logic [MAP_AW-1:0]     src_idx, dst_idx, wr_map_idx;
   logic                  row_done, last_row, elem_final;
   logic [CNT_W-1:0]      req_len, req_rows;
   logic [CHAN_CNT_W-1:0] req_src_chans, req_dst_chans;
   err_type               err;
   logic                  src_ok, dst_ok;
   logic                  run_empty;

   // Select a core's channel count
   function automatic logic [CHAN_CNT_W-1:0] chans_of(
      input logic [CORE_ID_W-1:0]  core,
      input logic [CHAN_CNT_W-1:0] c0,
      input logic [CHAN_CNT_W-1:0] c1,
      input logic [CHAN_CNT_W-1:0] c2,
      input logic [CHAN_CNT_W-1:0] c3
   );
      logic [CHAN_CNT_W-1:0] r;
      unique case (core)
         2'd0:    r = c0;
         2'd1:    r = c1;
         2'd2:    r = c2;
         default: r = c3;
      endcase
      return r;
   endfunction

   // Configuration registers, always ready
   always_ff @(posedge clock) begin
      if (reset) begin
         chan0_ff <= CHAN_CNT_W'(1);
         chan1_ff <= CHAN_CNT_W'(1);
         chan2_ff <= CHAN_CNT_W'(1);
         chan3_ff <= CHAN_CNT_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHAN_CORE0: chan0_ff <= csr_data;
            CSR_CHAN_CORE1: chan1_ff <= csr_data;
            CSR_CHAN_CORE2: chan2_ff <= csr_data;
            CSR_CHAN_CORE3: chan3_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Clearing pass counter
   assign clr_idx_in        = clr_idx_ff + MAP_AW'(1);
   assign status.clear_done = (clr_idx_ff == MAP_AW'(MAP_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clear) begin
         clr_idx_ff <= clr_idx_in;
      end
   end

   // Saturate length and row count, pick channel counts at load
   assign req_len  = (32'(req_data.length) > MAX_LENGTH) ? CNT_W'(MAX_LENGTH)
                                                          : CNT_W'(req_data.length);
   assign req_rows = (32'(req_data.stride) > MAX_STRIDE) ? CNT_W'(MAX_STRIDE)
                                                          : CNT_W'(req_data.stride);
   assign req_src_chans = chans_of(req_data.source_core,
                                   chan0_ff, chan1_ff, chan2_ff, chan3_ff);
   assign req_dst_chans = chans_of(req_data.dest_core,
                                   chan0_ff, chan1_ff, chan2_ff, chan3_ff);
   assign wr_map_idx    = MAP_AW'(req_data.source_core) * MAP_AW'(PAGE_SIZE)
                        + MAP_AW'(req_data.src_base);

   // Hold the transfer fields
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         source_core_ff <= req_data.source_core;
         dest_core_ff   <= req_data.dest_core;
         src_base_ff    <= req_data.src_base;
         dst_base_ff    <= req_data.dst_base;
         mode_ff        <= req_data.transfer_mode;
         len_ff         <= req_len;
         rows_ff        <= req_rows;
         en_ff          <= req_data.source_live;
         src_chans_ff   <= req_src_chans;
         dst_chans_ff   <= req_dst_chans;
      end
   end

   // Runs that give no result
   always_comb begin
      unique case (mode_ff)
         MODE_SCALAR:                            run_empty = 1'b0;
         MODE_SCATTER, MODE_GATHER, MODE_VECTOR: run_empty = (len_ff == '0);
         MODE_VEC2D: run_empty = (len_ff == '0) || (rows_ff == '0);
         default:                                run_empty = 1'b1;
      endcase
   end

   assign status.empty = run_empty;

   // Offsets and channels of the current element
   always_comb begin
      src_off = '0;
      dst_off = '0;
      sch     = '0;
      dch     = '0;
      unique case (mode_ff)
         MODE_SCATTER: begin
            src_off = elem_ff;
            dch     = elem_ff;
         end
         MODE_GATHER: begin
            dst_off = elem_ff;
            sch     = elem_ff;
         end
         MODE_VECTOR: begin
            sch = elem_ff;
            dch = elem_ff;
         end
         MODE_VEC2D: begin
            src_off = row_ff;
            dst_off = row_ff;
            sch     = elem_ff;
            dch     = elem_ff;
         end
         default: ;
      endcase
   end

   assign row_done   = (elem_ff + CNT_W'(1) == len_ff);
   assign last_row   = (row_ff + CNT_W'(1) == rows_ff);
   assign elem_final = (mode_ff == MODE_SCALAR) ? 1'b1
                     : (mode_ff == MODE_VEC2D)  ? (row_done && last_row)
                     : row_done;

   // Translate io addresses to table indexes
   assign src_sum      = SUM_W'(src_base_ff) + SUM_W'(src_off);
   assign dst_sum      = SUM_W'(dst_base_ff) + SUM_W'(dst_off);
   assign src_in_range = (32'(source_core_ff) < NUM_CORES) && (32'(src_sum) < PAGE_SIZE);
   assign dst_in_range = (32'(dest_core_ff) < NUM_CORES) && (32'(dst_sum) < PAGE_SIZE);
   assign src_idx      = MAP_AW'(source_core_ff) * MAP_AW'(PAGE_SIZE) + MAP_AW'(src_sum);
   assign dst_idx      = MAP_AW'(dest_core_ff) * MAP_AW'(PAGE_SIZE) + MAP_AW'(dst_sum);

   // Table: clearing pass or map write, two registered reads
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         map_mem[clr_idx_ff] <= '0;
      end else if (cmd.load && (req_data.req_type == REQ_MAP_WRITE) &&
                   (32'(req_data.source_core) < NUM_CORES)) begin
         map_mem[wr_map_idx] <= {req_data.map_valid, req_data.map_core_addr};
      end
      if (cmd.read) begin
         src_rd_ff <= map_mem[src_idx];
         dst_rd_ff <= map_mem[dst_idx];
      end
   end

   // Hold element checks for the check cycle
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         src_in_range_ff <= src_in_range;
         dst_in_range_ff <= dst_in_range;
         sch_ff          <= sch;
         dch_ff          <= dch;
         final_ff        <= elem_final;
      end
   end

   // Checks in order: source, destination, destination channel, source channel
   assign src_ok = src_in_range_ff && src_rd_ff[MAP_W-1];
   assign dst_ok = dst_in_range_ff && dst_rd_ff[MAP_W-1];

   always_comb begin
      priority if (!src_ok) begin
         err = ERR_SRC_UNMAPPED;
      end else if (!dst_ok) begin
         err = ERR_DST_UNMAPPED;
      end else if (32'(dch_ff) >= 32'(dst_chans_ff)) begin
         err = ERR_DST_CHANNEL;
      end else if (en_ff && (32'(sch_ff) >= 32'(src_chans_ff))) begin
         err = ERR_SRC_CHANNEL;
      end else begin
         err = ERR_NONE;
      end
   end

   assign status.stop = (err != ERR_NONE) || final_ff;

   // Advance the run counters
   always_comb begin
      elem_in = elem_ff + CNT_W'(1);
      row_in  = row_ff;
      if ((mode_ff == MODE_VEC2D) && row_done) begin
         elem_in = '0;
         row_in  = row_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         elem_ff <= '0;
         row_ff  <= '0;
      end else if (cmd.emit) begin
         if (status.stop) begin
            elem_ff <= '0;
            row_ff  <= '0;
         end else begin
            elem_ff <= elem_in;
            row_ff  <= row_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.read_from_repeater <= !en_ff;
         rsp_data_ff.error_code         <= err;
         if (err != ERR_NONE) begin
            rsp_data_ff.src_core_addr <= '0;
            rsp_data_ff.dst_core_addr <= '0;
            rsp_data_ff.source_chan   <= '0;
            rsp_data_ff.dest_chan     <= '0;
            rsp_data_ff.last          <= 1'b1;
         end else begin
            rsp_data_ff.src_core_addr <= src_rd_ff[CORE_ADDR_BITS-1:0];
            rsp_data_ff.dst_core_addr <= dst_rd_ff[CORE_ADDR_BITS-1:0];
            rsp_data_ff.source_chan   <= sch_ff[CHAN_W-1:0];
            rsp_data_ff.dest_chan     <= dch_ff[CHAN_W-1:0];
            rsp_data_ff.last          <= final_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### tb/dtas_checker.sv
// Checker for the DMA transfer address sequencer: predicts every result transaction
// from the accepted requests and channel count writes and compares field by field.
// Depends on dtas_pkg for the payload structs, codes and sizes.
module dtas_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  dtas_pkg::dtas_req_type          req_data,
   input  logic                            rsp_valid,
   input  dtas_pkg::dtas_rsp_type          rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [dtas_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dtas_pkg::CHAN_CNT_W-1:0] csr_data,
   output int                              fail_count,
   output int                              pending
);
   import dtas_pkg::*;

   // Shadow io-to-core table, channel counts and the queue of expected elements
   logic                      map_present [MAP_DEPTH];
   logic [CORE_ADDR_BITS-1:0] map_addr    [MAP_DEPTH];
   logic [CHAN_CNT_W-1:0]     chan_cnt    [NUM_CORES];
   dtas_rsp_type              element_q   [$];

   // Translate one io address plus offset; unmapped or off the page gives 0
   function automatic bit translate(int core, int io, int off,
                                    output logic [CORE_ADDR_BITS-1:0] addr);
      int a;
      addr = '0;
      a    = io + off;
      if (core >= NUM_CORES || a >= PAGE_SIZE) return 1'b0;
      if (!map_present[core * PAGE_SIZE + a]) return 1'b0;
      addr = map_addr[core * PAGE_SIZE + a];
      return 1'b1;
   endfunction

   // Queue one element; return 1 when it ends the run with an error
   function automatic bit queue_element(dtas_req_type r, int soff, int doff,
                                        int sch, int dch, bit fin);
      dtas_rsp_type              rsp;
      logic [CORE_ADDR_BITS-1:0] sa;
      logic [CORE_ADDR_BITS-1:0] da;
      err_type                   err;
      if (!translate(int'(r.source_core), int'(r.src_base), soff, sa))
         err = ERR_SRC_UNMAPPED;
      else if (!translate(int'(r.dest_core), int'(r.dst_base), doff, da))
         err = ERR_DST_UNMAPPED;
      else if (dch >= chan_cnt[r.dest_core]) err = ERR_DST_CHANNEL;
      else if (r.source_live && sch >= chan_cnt[r.source_core]) err = ERR_SRC_CHANNEL;
      else err = ERR_NONE;
      rsp.read_from_repeater = ~r.source_live;
      rsp.error_code         = err;
      if (err == ERR_NONE) begin
         rsp.src_core_addr = sa;
         rsp.dst_core_addr = da;
         rsp.source_chan   = sch[CHAN_W-1:0];
         rsp.dest_chan     = dch[CHAN_W-1:0];
         rsp.last          = fin;
      end else begin
         rsp.src_core_addr = '0;
         rsp.dst_core_addr = '0;
         rsp.source_chan   = '0;
         rsp.dest_chan     = '0;
         rsp.last          = 1'b1;
      end
      element_q.push_back(rsp);
      return err != ERR_NONE;
   endfunction

   // Apply a map write or expand a transfer into its element sequence
   function automatic void expand_request(dtas_req_type r);
      int len;
      int rows;
      bit stop;
      if (r.req_type == REQ_MAP_WRITE) begin
         map_present[int'(r.source_core) * PAGE_SIZE + int'(r.src_base)] = r.map_valid;
         map_addr[int'(r.source_core) * PAGE_SIZE + int'(r.src_base)]    = r.map_core_addr;
         return;
      end
      len  = (r.length > MAX_LENGTH) ? MAX_LENGTH : int'(r.length);
      rows = (r.stride > MAX_STRIDE) ? MAX_STRIDE : int'(r.stride);
      stop = 1'b0;
      unique case (r.transfer_mode)
         MODE_SCALAR: begin
            void'(queue_element(r, 0, 0, 0, 0, 1'b1));
         end
         MODE_SCATTER: begin
            for (int i = 0; i < len && !stop; i++)
               stop = queue_element(r, i, 0, 0, i, i == len - 1);
         end
         MODE_GATHER: begin
            for (int i = 0; i < len && !stop; i++)
               stop = queue_element(r, 0, i, i, 0, i == len - 1);
         end
         MODE_VECTOR: begin
            for (int i = 0; i < len && !stop; i++)
               stop = queue_element(r, 0, 0, i, i, i == len - 1);
         end
         MODE_VEC2D: begin
            for (int j = 0; j < rows && !stop; j++)
               for (int i = 0; i < len && !stop; i++)
                  stop = queue_element(r, j, j, i, i, i == len - 1 && j == rows - 1);
         end
         default: ;
      endcase
   endfunction

   function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Compare one result transaction against the oldest expected element
   function automatic void compare_result(dtas_rsp_type got);
      dtas_rsp_type want;
      if (element_q.size() == 0) begin
         $error("result transaction with nothing expected: %p", got);
         fail_count++;
         return;
      end
      want = element_q.pop_front();
      fail_count += field_diff("src_core_addr", 32'(want.src_core_addr),
                               32'(got.src_core_addr));
      fail_count += field_diff("dst_core_addr", 32'(want.dst_core_addr),
                               32'(got.dst_core_addr));
      fail_count += field_diff("source_chan", 32'(want.source_chan), 32'(got.source_chan));
      fail_count += field_diff("dest_chan", 32'(want.dest_chan), 32'(got.dest_chan));
      fail_count += field_diff("read_from_repeater", 32'(want.read_from_repeater),
                               32'(got.read_from_repeater));
      fail_count += field_diff("error_code", 32'(want.error_code), 32'(got.error_code));
      fail_count += field_diff("last", 32'(want.last), 32'(got.last));
   endfunction

   // Sample every channel at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < MAP_DEPTH; e++) map_present[e] = 1'b0;
         for (int c = 0; c < NUM_CORES; c++) chan_cnt[c] = CHAN_CNT_W'(1);
         element_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) compare_result(rsp_data);
         if (csr_valid && csr_ready) chan_cnt[csr_index] = csr_data;
         if (start && !busy) expand_request(req_data);
      end
      pending = element_q.size();
   end

endmodule

### tb/tb.sv
// Testbench top for the DMA transfer address sequencer: clock, reset, stimulus
// and verdict. Instantiates the block and dtas_checker; uses dtas_pkg.
module tb;
   import dtas_pkg::*;

   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 150;
   localparam int PHASE_ITEMS  = 55;
   localparam logic [MODE_W-1:0] MODE_UNDEFINED = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   dtas_req_type          req_data;
   logic                  rsp_valid;
   dtas_rsp_type          rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CHAN_CNT_W-1:0] csr_data;
   int                    fail_count;
   int                    pending;

   int send_idle;
   int sent_items;
   bit io_live [NUM_CORES][PAGE_SIZE];

   dma_transfer_address_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   dtas_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // End the run when no transaction of any kind moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet = 0;
         else quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   function automatic dtas_req_type random_req();
      logic [63:0] bits;
      bits = {$urandom(), $urandom()};
      return dtas_req_type'(bits[$bits(dtas_req_type)-1:0]);
   endfunction

   function automatic dtas_req_type map_req(int core, int io, logic [CORE_ADDR_BITS-1:0] addr,
                                            bit valid);
      dtas_req_type r;
      r               = random_req();
      r.req_type      = REQ_MAP_WRITE;
      r.source_core   = CORE_ID_W'(core);
      r.src_base      = IO_ADDR_BITS'(io);
      r.map_core_addr = addr;
      r.map_valid     = valid;
      return r;
   endfunction

   function automatic dtas_req_type xfer_req(logic [MODE_W-1:0] mode, int sc, int dc,
                                             int sb, int db, int len, int rows, bit en);
      dtas_req_type r;
      r               = random_req();
      r.req_type      = REQ_TRANSFER;
      r.transfer_mode = mode;
      r.source_core   = CORE_ID_W'(sc);
      r.dest_core     = CORE_ID_W'(dc);
      r.src_base      = IO_ADDR_BITS'(sb);
      r.dst_base      = IO_ADDR_BITS'(db);
      r.length        = LEN_W'(len);
      r.stride        = LEN_W'(rows);
      r.source_live   = en;
      return r;
   endfunction

   // Mostly in range, sometimes empty or oversized
   function automatic logic [LEN_W-1:0] pick_count();
      int v;
      v = $urandom_range(0, 19);
      if (v == 0) return '0;
      if (v < 3) return LEN_W'($urandom_range(MAX_LENGTH + 1, 15));
      return LEN_W'($urandom_range(1, MAX_LENGTH));
   endfunction

   // Bases cluster at the low end of the page or near its top edge
   function automatic logic [IO_ADDR_BITS-1:0] pick_base();
      if ($urandom_range(0, 3) == 0)
         return IO_ADDR_BITS'($urandom_range(PAGE_SIZE - 8, PAGE_SIZE - 1));
      return IO_ADDR_BITS'($urandom_range(0, 23));
   endfunction

   // Offer one request transaction, idling first, and hold it until busy reads low after an edge
   task automatic send_request(input dtas_req_type r);
      while ($urandom_range(0, 99) < send_idle) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (r.req_type == REQ_MAP_WRITE) io_live[r.source_core][r.src_base] = r.map_valid;
      sent_items++;
   endtask

   // Write all four channel counts
   task automatic load_chan_counts(input logic [CHAN_CNT_W-1:0] c0, c1, c2, c3);
      logic [CHAN_CNT_W-1:0] cnt [NUM_CORES];
      csr_index_type         idx;
      cnt = '{c0, c1, c2, c3};
      idx = CSR_CHAN_CORE0;
      repeat (NUM_CORES) begin
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= cnt[idx];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         idx = idx.next();
      end
      csr_valid <= 1'b0;
   endtask

   // Drop start, drain expected results, then let a full run's worth of cycles pass
   task automatic settle();
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Map every io address a run touches, unless already live, then issue the run
   task automatic send_prepared_transfer();
      dtas_req_type r;
      int len_eff;
      int rows_eff;
      int span_src;
      int span_dst;
      r               = random_req();
      r.req_type      = REQ_TRANSFER;
      r.transfer_mode = MODE_W'($urandom_range(MODE_SCALAR, MODE_VEC2D));
      r.length        = pick_count();
      r.stride        = pick_count();
      r.source_live   = ($urandom_range(0, 4) != 0);
      r.src_base      = pick_base();
      r.dst_base      = pick_base();
      len_eff  = (r.length > MAX_LENGTH) ? MAX_LENGTH : int'(r.length);
      rows_eff = (r.stride > MAX_STRIDE) ? MAX_STRIDE : int'(r.stride);
      unique case (r.transfer_mode)
         MODE_SCATTER: begin span_src = len_eff;  span_dst = 1;        end
         MODE_GATHER:  begin span_src = 1;        span_dst = len_eff;  end
         MODE_VEC2D:   begin span_src = rows_eff; span_dst = rows_eff; end
         default:      begin span_src = 1;        span_dst = 1;        end
      endcase
      for (int o = 0; o < span_src; o++)
         if (int'(r.src_base) + o < PAGE_SIZE && !io_live[r.source_core][int'(r.src_base) + o])
            send_request(map_req(int'(r.source_core), int'(r.src_base) + o,
                                 CORE_ADDR_BITS'($urandom()), $urandom_range(0, 19) != 0));
      for (int o = 0; o < span_dst; o++)
         if (int'(r.dst_base) + o < PAGE_SIZE && !io_live[r.dest_core][int'(r.dst_base) + o])
            send_request(map_req(int'(r.dest_core), int'(r.dst_base) + o,
                                 CORE_ADDR_BITS'($urandom()), $urandom_range(0, 19) != 0));
      send_request(r);
   endtask

   // Mostly prepared runs; the rest raw noise and unprepared transfers
   task automatic run_random(input int quota);
      int stop_at;
      int pick;
      dtas_req_type r;
      stop_at = sent_items + quota;
      while (sent_items < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            send_prepared_transfer();
         end else if (pick < 90) begin
            send_request(random_req());
         end else begin
            r          = random_req();
            r.req_type = REQ_TRANSFER;
            send_request(r);
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      send_idle  = 7;
      sent_items = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: cores 0 and 1 wide, core 2 with two channels, core 3 with one
      load_chan_counts(4'd8, 4'd8, 4'd2, 4'd1);
      send_request(map_req(0, 0, 12'hFFF, 1'b1));
      send_request(map_req(1, PAGE_SIZE - 1, 12'h000, 1'b1));
      send_request(map_req(0, 1, 12'hA5A, 1'b1));
      send_request(map_req(3, 9, 12'h123, 1'b1));
      send_request(map_req(2, 4, 12'h800, 1'b1));
      send_request(xfer_req(MODE_SCALAR, 0, 1, 0, PAGE_SIZE - 1, 1, 1, 1'b1));
      send_request(xfer_req(MODE_SCALAR, 0, 1, 0, PAGE_SIZE - 1, 1, 1, 1'b0));
      // unmapped source, then unmapped destination
      send_request(xfer_req(MODE_SCALAR, 2, 0, 7, 0, 1, 1, 1'b1));
      send_request(xfer_req(MODE_SCALAR, 0, 3, 0, 3, 1, 1, 1'b1));
      // scatter runs into a hole; scatter overruns the destination's channels
      send_request(xfer_req(MODE_SCATTER, 0, 1, 0, PAGE_SIZE - 1, 3, 1, 1'b1));
      send_request(xfer_req(MODE_SCATTER, 0, 3, 0, 9, 2, 1, 1'b1));
      // gather clean, then into a destination hole
      send_request(xfer_req(MODE_GATHER, 2, 0, 4, 0, 2, 1, 1'b1));
      send_request(xfer_req(MODE_GATHER, 2, 0, 4, 0, 3, 1, 1'b1));
      // vector overruns source channels only when the source is live
      send_request(xfer_req(MODE_VECTOR, 2, 0, 4, 0, 3, 1, 1'b1));
      send_request(xfer_req(MODE_VECTOR, 2, 0, 4, 0, 3, 1, 1'b0));
      // source address walks off the top of the page
      send_request(xfer_req(MODE_SCATTER, 1, 0, PAGE_SIZE - 1, 0, 2, 1, 1'b1));
      send_request(xfer_req(MODE_VEC2D, 0, 0, 0, 0, 2, 2, 1'b1));
      // oversized length saturates; empty runs and an unknown mode give nothing
      send_request(xfer_req(MODE_VECTOR, 0, 1, 0, PAGE_SIZE - 1, 15, 1, 1'b1));
      send_request(xfer_req(MODE_VECTOR, 0, 1, 0, PAGE_SIZE - 1, 0, 1, 1'b1));
      send_request(xfer_req(MODE_VEC2D, 0, 0, 0, 0, 2, 0, 1'b1));
      send_request(xfer_req(MODE_UNDEFINED, 0, 0, 0, 0, 2, 2, 1'b1));
      // clear an entry, then hit it directly and from an oversized 2D run
      send_request(map_req(0, 1, 12'h5A5, 1'b0));
      send_request(xfer_req(MODE_SCALAR, 0, 0, 1, 0, 1, 1, 1'b1));
      send_request(xfer_req(MODE_VEC2D, 0, 0, 0, 0, 1, 15, 1'b1));

      // Random phases: fast, slow, then back-to-back sender; two settings each
      for (int p = 0; p < 3; p++) begin
         for (int s = 0; s < 2; s++) begin
            settle();
            send_idle = (p == 0) ? 7 : (p == 1) ? 83 : 0;
            if (s == 0 && p == 1)
               load_chan_counts(4'd1, 4'd1, 4'd1, 4'd1);
            else if (s == 0 && p == 2)
               load_chan_counts(4'd8, 4'd8, 4'd8, 4'd8);
            else
               load_chan_counts(CHAN_CNT_W'($urandom_range(1, MAX_CHANNELS)),
                                CHAN_CNT_W'($urandom_range(1, MAX_CHANNELS)),
                                CHAN_CNT_W'($urandom_range(1, MAX_CHANNELS)),
                                CHAN_CNT_W'($urandom_range(1, MAX_CHANNELS)));
            run_random(PHASE_ITEMS);
         end
      end

      settle();
      @(negedge clock);
      if (fail_count == 0 && pending == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

### dma_transfer_address_sequencer.f
hw/rtl/dtas_pkg.sv
hw/rtl/dtas_ctrl.sv
hw/rtl/dtas_datapath.sv
hw/rtl/dma_transfer_address_sequencer.sv
tb/dtas_checker.sv
tb/tb.sv
